// ===== design/clw_pkg.sv =====
// Package for the cubic Lagrange weight pipeline: widths, codes and shared types.
// Used by the channel interfaces and the top level; depends on nothing.
package clw_pkg;

    localparam int POS_W     = 32;              // Q16.16 grid coordinate
    localparam int WGT_W     = 32;              // Q4.28 weight
    localparam int STAT_W    = 2;
    localparam int PTS       = 4;               // stencil points
    localparam int FACTORS   = 3;               // factors in each product
    localparam int OFS_W     = POS_W + 3;       // doubled offset from the target
    localparam int DIF_W     = OFS_W + 1;       // difference of two offsets
    localparam int MAG_W     = DIF_W;           // magnitude of any factor
    localparam int HALF_W    = MAG_W / 2;       // multiplier slice
    localparam int PP_W      = MAG_W + HALF_W;  // one partial product
    localparam int P2_W      = 2 * MAG_W;
    localparam int P3_W      = 3 * MAG_W;
    localparam int CHUNKS    = P2_W / HALF_W;
    localparam int RND_SH    = 29;              // 28 fraction bits plus a rounding bit
    localparam int QUO_W     = WGT_W + 1;       // quotient bits kept below overflow
    localparam int NUM_LOW_W = QUO_W - RND_SH;  // numerator bits fed into the divider
    localparam int DIV_STEPS = QUO_W;

    localparam logic [QUO_W-1:0] LIM_POS = QUO_W'((64'd1 << (WGT_W - 1)) - 64'd1);
    localparam logic [QUO_W-1:0] LIM_NEG = QUO_W'(64'd1 << (WGT_W - 1));

    typedef enum logic {
        CMD_C2N = 1'b0,
        CMD_N2C = 1'b1
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_COINC = 2'd1,
        STAT_SAT   = 2'd2
    } status_t;

    // Per-word side information that travels alongside the arithmetic.
    typedef struct packed {
        logic [PTS-1:0] neg;
        logic           coinc;
    } clw_side_t;

endpackage

// ===== design/clw_in_if.sv =====
// Input channel of the cubic Lagrange weight block: valid/ready plus one row of coordinates.
// Depends on clw_pkg.
interface clw_in_if;
    import clw_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    command;
    logic signed [POS_W-1:0] pos_m2;
    logic signed [POS_W-1:0] pos_m1;
    logic signed [POS_W-1:0] pos_0;
    logic signed [POS_W-1:0] pos_p1;
    logic signed [POS_W-1:0] pos_p2;

    modport source (output valid, command, pos_m2, pos_m1, pos_0, pos_p1, pos_p2,
                    input ready);
    modport sink   (input valid, command, pos_m2, pos_m1, pos_0, pos_p1, pos_p2,
                    output ready);
endinterface

// ===== design/clw_out_if.sv =====
// Output channel of the cubic Lagrange weight block: valid/ready plus four weights and status.
// Depends on clw_pkg.
interface clw_out_if;
    import clw_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [WGT_W-1:0] weight_0;
    logic signed [WGT_W-1:0] weight_1;
    logic signed [WGT_W-1:0] weight_2;
    logic signed [WGT_W-1:0] weight_3;
    logic [STAT_W-1:0]       status;

    modport source (output valid, weight_0, weight_1, weight_2, weight_3, status,
                    input ready);
    modport sink   (input valid, weight_0, weight_1, weight_2, weight_3, status,
                    output ready);
endinterface

// ===== design/cubic_lagrange_weights.sv =====
// Cubic Lagrange weight pipeline: one word of four Q4.28 weights per input word.
// Depends on clw_pkg, clw_in_if and clw_out_if.
//
// The block accepts one word per clock while the output is not stalled and
// returns one result word per input word, in order. The pipeline depth is
// set by the exact restoring division: each of the 33 quotient bits of every
// weight has its own register stage, preceded by eight stages that capture
// the word, form the offsets, the differences and the two triple products,
// and set up the divider, and followed by the rounding and saturation logic
// that feeds the output register.
// All stages advance together; a stall at the output holds the whole pipeline,
// so nothing is lost or repeated, and ready drops only while a finished word
// waits at the output and is not being taken.
module cubic_lagrange_weights (
    input  logic      clk,
    input  logic      rst_n,
    clw_in_if.sink    req,
    clw_out_if.source rsp
);
    import clw_pkg::*;

    // The whole pipeline moves when the output register is free or being read.
    logic adv;

    // Stage 1: raw input word.
    logic                    s1_valid_reg;
    logic                    s1_cmd_reg;
    logic signed [POS_W-1:0] s1_pos_reg [5];

    // Stage 2: the four stencil offsets, doubled so that midpoints stay exact.
    logic                    s2_valid_reg;
    logic signed [OFS_W-1:0] s2_ofs_reg [PTS];
    logic signed [OFS_W-1:0] s2_ofs_next [PTS];

    // Stage 3: magnitudes of the three numerator (side 0) and denominator
    // (side 1) factors of each weight, and the sign of each weight.
    logic             s3_valid_reg;
    logic [MAG_W-1:0] s3_mag_reg  [PTS][2][FACTORS];
    logic [MAG_W-1:0] s3_mag_next [PTS][2][FACTORS];
    clw_side_t        s3_side_reg;
    clw_side_t        s3_side_next;

    // Stages 4 to 7: the triple products, cut into 36 by 18 bit multiplies.
    logic             s4_valid_reg;
    logic [PP_W-1:0]  s4_lo_reg [PTS][2];
    logic [PP_W-1:0]  s4_hi_reg [PTS][2];
    logic [MAG_W-1:0] s4_z_reg  [PTS][2];
    clw_side_t        s4_side_reg;

    logic             s5_valid_reg;
    logic [P2_W-1:0]  s5_p2_reg [PTS][2];
    logic [MAG_W-1:0] s5_z_reg  [PTS][2];
    clw_side_t        s5_side_reg;

    logic             s6_valid_reg;
    logic [PP_W-1:0]  s6_pp_reg [PTS][2][CHUNKS];
    clw_side_t        s6_side_reg;

    logic             s7_valid_reg;
    logic [P3_W-1:0]  s7_p3_reg [PTS][2];
    clw_side_t        s7_side_reg;

    // Division pipeline: index 0 is the set-up stage, index j+1 holds the
    // state after quotient bit j.
    logic                 dv_valid_reg [DIV_STEPS+1];
    clw_side_t            dv_side_reg  [DIV_STEPS+1];
    logic [P3_W-1:0]      dv_rem_reg   [DIV_STEPS+1][PTS];
    logic [P3_W-1:0]      dv_den_reg   [DIV_STEPS+1][PTS];
    logic [QUO_W-1:0]     dv_quo_reg   [DIV_STEPS+1][PTS];
    logic [NUM_LOW_W-1:0] dv_nlow_reg  [DIV_STEPS+1][PTS];
    logic                 dv_ovf_reg   [DIV_STEPS+1][PTS];
    logic [P3_W-1:0]      dv_rem_next  [DIV_STEPS][PTS];
    logic [QUO_W-1:0]     dv_quo_next  [DIV_STEPS][PTS];

    // Output register.
    logic                    out_valid_reg;
    logic signed [WGT_W-1:0] out_w_reg  [PTS];
    logic signed [WGT_W-1:0] out_w_next [PTS];
    logic [STAT_W-1:0]       out_status_reg;
    logic [STAT_W-1:0]       out_status_next;

    function automatic logic [MAG_W-1:0] mag_of(input logic signed [DIF_W-1:0] v);
        logic [MAG_W-1:0] r;
        r = v[DIF_W-1] ? MAG_W'(-v) : MAG_W'(v);
        return r;
    endfunction

    assign adv       = !out_valid_reg || rsp.ready;
    assign req.ready = adv;

    // Offsets. In centre-to-node mode the points are cell midpoints around
    // the node; in node-to-centre mode they are nodes around the midpoint of
    // pos_0 and pos_p1. Everything is doubled, which cancels in every ratio.
    always_comb
    begin
        logic signed [OFS_W-1:0] gm2, gm1, g0, gp1, gp2;
        gm2 = OFS_W'(s1_pos_reg[0]);
        gm1 = OFS_W'(s1_pos_reg[1]);
        g0  = OFS_W'(s1_pos_reg[2]);
        gp1 = OFS_W'(s1_pos_reg[3]);
        gp2 = OFS_W'(s1_pos_reg[4]);
        if (s1_cmd_reg == CMD_N2C)
        begin
            s2_ofs_next[0] = gm1 + gm1 - g0 - gp1;
            s2_ofs_next[1] = g0 - gp1;
            s2_ofs_next[2] = gp1 - g0;
            s2_ofs_next[3] = gp2 + gp2 - g0 - gp1;
        end
        else
        begin
            s2_ofs_next[0] = gm2 + gm1 - g0 - g0;
            s2_ofs_next[1] = gm1 - g0;
            s2_ofs_next[2] = gp1 - g0;
            s2_ofs_next[3] = gp1 + gp2 - g0 - g0;
        end
    end

    // Weight k is -(product of the other offsets) / (product of the
    // differences from point k). Signs are tracked apart from magnitudes.
    always_comb
    begin
        logic signed [DIF_W-1:0] ea, eb, ec, ed;
        logic signed [DIF_W-1:0] dab, dac, dad, dbc, dbd, dcd;
        logic sa, sb, sc, sd, sab, sac, sad, sbc, sbd, scd;
        ea  = DIF_W'(s2_ofs_reg[0]);
        eb  = DIF_W'(s2_ofs_reg[1]);
        ec  = DIF_W'(s2_ofs_reg[2]);
        ed  = DIF_W'(s2_ofs_reg[3]);
        dab = ea - eb;
        dac = ea - ec;
        dad = ea - ed;
        dbc = eb - ec;
        dbd = eb - ed;
        dcd = ec - ed;
        sa  = ea[DIF_W-1];
        sb  = eb[DIF_W-1];
        sc  = ec[DIF_W-1];
        sd  = ed[DIF_W-1];
        sab = dab[DIF_W-1];
        sac = dac[DIF_W-1];
        sad = dad[DIF_W-1];
        sbc = dbc[DIF_W-1];
        sbd = dbd[DIF_W-1];
        scd = dcd[DIF_W-1];

        s3_mag_next[0][0][0] = mag_of(eb);
        s3_mag_next[0][0][1] = mag_of(ec);
        s3_mag_next[0][0][2] = mag_of(ed);
        s3_mag_next[0][1][0] = mag_of(dab);
        s3_mag_next[0][1][1] = mag_of(dac);
        s3_mag_next[0][1][2] = mag_of(dad);

        s3_mag_next[1][0][0] = mag_of(ea);
        s3_mag_next[1][0][1] = mag_of(ec);
        s3_mag_next[1][0][2] = mag_of(ed);
        s3_mag_next[1][1][0] = mag_of(dab);
        s3_mag_next[1][1][1] = mag_of(dbc);
        s3_mag_next[1][1][2] = mag_of(dbd);

        s3_mag_next[2][0][0] = mag_of(ea);
        s3_mag_next[2][0][1] = mag_of(eb);
        s3_mag_next[2][0][2] = mag_of(ed);
        s3_mag_next[2][1][0] = mag_of(dac);
        s3_mag_next[2][1][1] = mag_of(dbc);
        s3_mag_next[2][1][2] = mag_of(dcd);

        s3_mag_next[3][0][0] = mag_of(ea);
        s3_mag_next[3][0][1] = mag_of(eb);
        s3_mag_next[3][0][2] = mag_of(ec);
        s3_mag_next[3][1][0] = mag_of(dad);
        s3_mag_next[3][1][1] = mag_of(dbd);
        s3_mag_next[3][1][2] = mag_of(dcd);

        // A reversed difference is nonzero whenever the weights are used,
        // so its sign is the inverse of the forward one.
        s3_side_next.neg[0] = ~(sb ^ sc ^ sd ^ sab ^ sac ^ sad);
        s3_side_next.neg[1] = ~(sa ^ sc ^ sd ^ ~sab ^ sbc ^ sbd);
        s3_side_next.neg[2] = ~(sa ^ sb ^ sd ^ ~sac ^ ~sbc ^ scd);
        s3_side_next.neg[3] = ~(sa ^ sb ^ sc ^ ~sad ^ ~sbd ^ ~scd);
        s3_side_next.coinc  = (dab == '0) || (dac == '0) || (dad == '0) ||
                              (dbc == '0) || (dbd == '0) || (dcd == '0);
    end

    // One restoring step per stage. The numerator enters as its top bits
    // and then its low bits followed by the zeros of the Q4.28 scaling.
    // The low bits shift up one place per stage, so the top bit is always
    // the next one in, and zeros follow once they are used up.
    always_comb
    begin
        logic [P3_W:0] cand;
        logic          nbit;
        logic          ge;
        for (int j = 0; j < DIV_STEPS; j++)
        begin
            for (int k = 0; k < PTS; k++)
            begin
                nbit = dv_nlow_reg[j][k][NUM_LOW_W-1];
                cand = {dv_rem_reg[j][k], nbit};
                ge   = cand >= {1'b0, dv_den_reg[j][k]};
                dv_rem_next[j][k] = ge ? P3_W'(cand - {1'b0, dv_den_reg[j][k]})
                                       : P3_W'(cand);
                dv_quo_next[j][k] = {dv_quo_reg[j][k][QUO_W-2:0], ge};
            end
        end
    end

    // Round half up, saturate, apply the sign; coincident points clear every weight.
    always_comb
    begin
        logic [QUO_W:0]   qsum;
        logic [QUO_W-1:0] rq;
        logic [QUO_W-1:0] lim;
        logic             sat;
        logic             any_sat;
        logic [WGT_W-1:0] m;
        any_sat = 1'b0;
        for (int k = 0; k < PTS; k++)
        begin
            qsum = {1'b0, dv_quo_reg[DIV_STEPS][k]} + (QUO_W+1)'(1);
            rq   = qsum[QUO_W:1];
            lim  = dv_side_reg[DIV_STEPS].neg[k] ? LIM_NEG : LIM_POS;
            sat  = dv_ovf_reg[DIV_STEPS][k] || (rq > lim);
            m    = sat ? lim[WGT_W-1:0] : rq[WGT_W-1:0];
            any_sat = any_sat || sat;
            if (dv_side_reg[DIV_STEPS].coinc)
            begin
                out_w_next[k] = '0;
            end
            else
            begin
                out_w_next[k] = dv_side_reg[DIV_STEPS].neg[k] ? -$signed(m) : $signed(m);
            end
        end
        if (dv_side_reg[DIV_STEPS].coinc)
        begin
            out_status_next = STAT_COINC;
        end
        else if (any_sat)
        begin
            out_status_next = STAT_SAT;
        end
        else
        begin
            out_status_next = STAT_OK;
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            s7_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int j = 0; j <= DIV_STEPS; j++)
            begin
                dv_valid_reg[j] <= 1'b0;
            end
        end
        else if (adv)
        begin
            s1_valid_reg    <= req.valid;
            s2_valid_reg    <= s1_valid_reg;
            s3_valid_reg    <= s2_valid_reg;
            s4_valid_reg    <= s3_valid_reg;
            s5_valid_reg    <= s4_valid_reg;
            s6_valid_reg    <= s5_valid_reg;
            s7_valid_reg    <= s6_valid_reg;
            dv_valid_reg[0] <= s7_valid_reg;
            for (int j = 0; j < DIV_STEPS; j++)
            begin
                dv_valid_reg[j+1] <= dv_valid_reg[j];
            end
            out_valid_reg <= dv_valid_reg[DIV_STEPS];
        end
    end

    // Data path registers.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_cmd_reg    <= req.command;
            s1_pos_reg[0] <= req.pos_m2;
            s1_pos_reg[1] <= req.pos_m1;
            s1_pos_reg[2] <= req.pos_0;
            s1_pos_reg[3] <= req.pos_p1;
            s1_pos_reg[4] <= req.pos_p2;

            s2_ofs_reg  <= s2_ofs_next;
            s3_mag_reg  <= s3_mag_next;
            s3_side_reg <= s3_side_next;

            s4_side_reg <= s3_side_reg;
            s5_side_reg <= s4_side_reg;
            s6_side_reg <= s5_side_reg;
            s7_side_reg <= s6_side_reg;

            for (int k = 0; k < PTS; k++)
            begin
                for (int s = 0; s < 2; s++)
                begin
                    s4_lo_reg[k][s] <= PP_W'(s3_mag_reg[k][s][0]) *
                                       PP_W'(s3_mag_reg[k][s][1][HALF_W-1:0]);
                    s4_hi_reg[k][s] <= PP_W'(s3_mag_reg[k][s][0]) *
                                       PP_W'(s3_mag_reg[k][s][1][MAG_W-1:HALF_W]);
                    s4_z_reg[k][s]  <= s3_mag_reg[k][s][2];

                    s5_p2_reg[k][s] <= P2_W'(s4_lo_reg[k][s]) +
                                       (P2_W'(s4_hi_reg[k][s]) << HALF_W);
                    s5_z_reg[k][s]  <= s4_z_reg[k][s];

                    for (int c = 0; c < CHUNKS; c++)
                    begin
                        s6_pp_reg[k][s][c] <= PP_W'(s5_p2_reg[k][s][HALF_W*c +: HALF_W]) *
                                              PP_W'(s5_z_reg[k][s]);
                    end

                    s7_p3_reg[k][s] <= P3_W'(s6_pp_reg[k][s][0]) +
                                       (P3_W'(s6_pp_reg[k][s][1]) << HALF_W) +
                                       (P3_W'(s6_pp_reg[k][s][2]) << (2 * HALF_W)) +
                                       (P3_W'(s6_pp_reg[k][s][3]) << (3 * HALF_W));
                end

                // Set-up: a quotient that needs more than QUO_W bits saturates.
                dv_ovf_reg[0][k]  <= {{NUM_LOW_W{1'b0}}, s7_p3_reg[k][0]} >=
                                     {s7_p3_reg[k][1], {NUM_LOW_W{1'b0}}};
                dv_rem_reg[0][k]  <= s7_p3_reg[k][0] >> NUM_LOW_W;
                dv_den_reg[0][k]  <= s7_p3_reg[k][1];
                dv_nlow_reg[0][k] <= s7_p3_reg[k][0][NUM_LOW_W-1:0];
                dv_quo_reg[0][k]  <= '0;
            end
            dv_side_reg[0] <= s7_side_reg;

            for (int j = 0; j < DIV_STEPS; j++)
            begin
                dv_side_reg[j+1] <= dv_side_reg[j];
                for (int k = 0; k < PTS; k++)
                begin
                    dv_rem_reg[j+1][k]  <= dv_rem_next[j][k];
                    dv_quo_reg[j+1][k]  <= dv_quo_next[j][k];
                    dv_den_reg[j+1][k]  <= dv_den_reg[j][k];
                    dv_nlow_reg[j+1][k] <= dv_nlow_reg[j][k] << 1;
                    dv_ovf_reg[j+1][k]  <= dv_ovf_reg[j][k];
                end
            end

            out_w_reg      <= out_w_next;
            out_status_reg <= out_status_next;
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.weight_0 = out_w_reg[0];
    assign rsp.weight_1 = out_w_reg[1];
    assign rsp.weight_2 = out_w_reg[2];
    assign rsp.weight_3 = out_w_reg[3];
    assign rsp.status   = out_status_reg;

`ifndef SYNTHESIS
    // Coincident points must clear every weight.
    a_coinc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == STAT_COINC) |->
        (out_w_reg[0] == '0 && out_w_reg[1] == '0 &&
         out_w_reg[2] == '0 && out_w_reg[3] == '0))
        else $error("coincident result with nonzero weight");

    // A saturated status means some weight sits at a bound.
    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == STAT_SAT) |->
        (out_w_reg[0] == 32'sh7FFFFFFF || out_w_reg[0] == -32'sh80000000 ||
         out_w_reg[1] == 32'sh7FFFFFFF || out_w_reg[1] == -32'sh80000000 ||
         out_w_reg[2] == 32'sh7FFFFFFF || out_w_reg[2] == -32'sh80000000 ||
         out_w_reg[3] == 32'sh7FFFFFFF || out_w_reg[3] == -32'sh80000000))
        else $error("saturated status without a clamped weight");

    // After the last step the remainder of weight 0 stays below the divisor.
    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        (dv_valid_reg[DIV_STEPS] && !dv_side_reg[DIV_STEPS].coinc &&
         !dv_ovf_reg[DIV_STEPS][0]) |->
        (dv_rem_reg[DIV_STEPS][0] < dv_den_reg[DIV_STEPS][0]))
        else $error("division remainder not below divisor");
`endif

endmodule
